[rtl/stack_pop_sequence_checker_core_assert.svh]
// Assertion macros shared by the checker RTL.
`ifndef STACK_POP_SEQUENCE_CHECKER_CORE_ASSERT_SVH
`define STACK_POP_SEQUENCE_CHECKER_CORE_ASSERT_SVH

// same-cycle implication
`define SPSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spsc assertion failed");

// next-cycle implication
`define SPSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spsc assertion failed");

`endif

[rtl/spsc_pkg.sv]
// Package: sizes, types and codes of the stack pop sequence checker.
package spsc_pkg;

   localparam int MAX_LEN   = 1024;
   localparam int MAX_DEPTH = 1024;

   localparam int VAL_W   = 11;
   localparam int CFG_W   = 11;
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int NP_W    = $clog2(MAX_LEN + 2);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   localparam int W_A = (VAL_W > NP_W) ? VAL_W : NP_W;
   localparam int W_B = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
   localparam int W_C = (W_A > W_B) ? W_A : W_B;
   localparam int CMP_W = ((W_C > CNT_W) ? W_C : CNT_W) + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index
   localparam logic REG_SEQ_LEN  = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   localparam logic [CFG_W-1:0] SEQ_LEN_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(1024);

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PUSH = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

endpackage

[rtl/spsc_req_if.sv]
// Interface: input channel carrying popped values.
interface spsc_req_if;
   logic                     valid;
   logic                     ready;
   logic [spsc_pkg::VAL_W-1:0] popped_value;

   modport source (output valid, output popped_value, input ready);
   modport sink (input valid, input popped_value, output ready);
endinterface

[rtl/spsc_rsp_if.sv]
// Interface: result channel carrying the running verdict.
interface spsc_rsp_if;
   logic valid;
   logic ready;
   logic still_possible;
   logic sequence_end;

   modport source (output valid, output still_possible, output sequence_end, input ready);
   modport sink (input valid, input still_possible, input sequence_end, output ready);
endinterface

[rtl/spsc_cell.sv]
// One stack cell: holds an entry and shifts with its neighbors.
module spsc_cell (
   input  logic                       clock,
   input  spsc_pkg::stack_op_type     op,
   input  logic [spsc_pkg::VAL_W-1:0] above_data,
   input  logic [spsc_pkg::VAL_W-1:0] below_data,
   output logic [spsc_pkg::VAL_W-1:0] data
);

   logic [spsc_pkg::VAL_W-1:0] data_ff;
   logic [spsc_pkg::VAL_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (op.push) begin
         data_in = above_data;
      end else if (op.pop) begin
         data_in = below_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/spsc_stack_chain.sv]
// Stack as a chain of shifting cells; cell 0 is the top of stack.
module spsc_stack_chain (
   input  logic                       clock,
   input  spsc_pkg::stack_op_type     op,
   input  logic [spsc_pkg::VAL_W-1:0] push_data,
   output logic [spsc_pkg::VAL_W-1:0] top_data
);

   logic [spsc_pkg::VAL_W-1:0] cell_data [spsc_pkg::MAX_DEPTH];

   for (genvar i = 0; i < spsc_pkg::MAX_DEPTH; i++) begin : g_cell
      logic [spsc_pkg::VAL_W-1:0] above;
      logic [spsc_pkg::VAL_W-1:0] below;

      if (i == 0) begin : g_first
         assign above = push_data;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end

      if (i == spsc_pkg::MAX_DEPTH - 1) begin : g_last
         assign below = cell_data[i];
      end else begin : g_inner
         assign below = cell_data[i+1];
      end

      spsc_cell u_cell (
         .clock      (clock),
         .op         (op),
         .above_data (above),
         .below_data (below),
         .data       (cell_data[i])
      );
   end

   assign top_data = cell_data[0];

endmodule

[rtl/stack_pop_sequence_checker_core.sv]
// Top level: stack pop sequence checker with APB-style register port.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+--------------------------------
//   req_chan | in  | valid/ready    | popped_value[10:0]
//   rsp_chan | out | valid/ready    | still_possible, sequence_end
//   csr_*    | in  | psel/penable   | sequence_length, stack_capacity
//
// A transaction that pops, fails, or needs no extra push posts its result in the cycle after it is accepted.
// Otherwise k = popped_value - next_push pushes run through the cell chain,
// one per cycle, then the done state posts the result once the output is free.
// Pushes per sequence total at most N.
// Synchronous active-high reset; no clearing pass is needed.
// A stalled result register holds the next transaction off until drained.
`include "stack_pop_sequence_checker_core_assert.svh"

module stack_pop_sequence_checker_core (
   input  logic                                clock,
   input  logic                                reset,
   spsc_req_if.sink                            req_chan,
   spsc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spsc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [spsc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [spsc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CMP_W   = spsc_pkg::CMP_W;
   localparam int VAL_W   = spsc_pkg::VAL_W;
   localparam int CFG_W   = spsc_pkg::CFG_W;
   localparam int DEPTH_W = spsc_pkg::DEPTH_W;
   localparam int NP_W    = spsc_pkg::NP_W;
   localparam int CNT_W   = spsc_pkg::CNT_W;

   logic [CFG_W-1:0]   seq_len_ff, seq_len_in;
   logic [CFG_W-1:0]   capacity_ff, capacity_in;
   logic [1:0]         state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [NP_W-1:0]    next_push_ff, next_push_in;
   logic [CNT_W-1:0]   item_count_ff, item_count_in;
   logic               failed_ff, failed_in;
   logic [VAL_W-1:0]   target_ff, target_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               still_ff, still_in;
   logic               end_ff, end_in;

   logic                   csr_write;
   logic                   out_free;
   logic                   req_fire;
   logic [VAL_W-1:0]       top_value;
   spsc_pkg::stack_op_type stack_op;

   logic [CMP_W-1:0] v_w, np_w, top_w, n_w, cap_w, need_w, cnt_w;
   logic             hit, bad_val, over, one_shot;
   logic             finish, fail_now, seq_done;
   logic [CNT_W-1:0] cnt_inc;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == spsc_pkg::REG_CAPACITY) ?
                       spsc_pkg::CSR_DATA_W'(capacity_ff) :
                       spsc_pkg::CSR_DATA_W'(seq_len_ff);

   always_comb begin
      seq_len_in  = seq_len_ff;
      capacity_in = capacity_ff;
      if (csr_write) begin
         if (csr_paddr[2] == spsc_pkg::REG_CAPACITY) begin
            capacity_in = csr_pwdata[CFG_W-1:0];
         end else begin
            seq_len_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   // clamped limits
   always_comb begin
      n_w   = CMP_W'(seq_len_ff);
      cap_w = CMP_W'(capacity_ff);
      if (seq_len_ff == '0) begin
         n_w = CMP_W'(1);
      end else if (n_w > CMP_W'(spsc_pkg::MAX_LEN)) begin
         n_w = CMP_W'(spsc_pkg::MAX_LEN);
      end
      if (capacity_ff == '0) begin
         cap_w = CMP_W'(1);
      end else if (cap_w > CMP_W'(spsc_pkg::MAX_DEPTH)) begin
         cap_w = CMP_W'(spsc_pkg::MAX_DEPTH);
      end
   end

   // decision for an arriving value
   assign v_w      = CMP_W'(req_chan.popped_value);
   assign np_w     = CMP_W'(next_push_ff);
   assign top_w    = CMP_W'(depth_ff);
   assign hit      = (depth_ff != '0) && (top_value == req_chan.popped_value);
   assign bad_val  = (v_w == '0) || (v_w < np_w) || (v_w > n_w);
   assign need_w   = v_w - np_w + CMP_W'(1);
   assign over     = (top_w + need_w) > cap_w;
   assign one_shot = (v_w == np_w);

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == spsc_pkg::S_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign cnt_inc  = item_count_ff + CNT_W'(1);
   assign cnt_w    = CMP_W'(cnt_inc);
   assign seq_done = cnt_w >= n_w;

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      next_push_in  = next_push_ff;
      item_count_in = item_count_ff;
      failed_in     = failed_ff;
      target_in     = target_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      still_in      = still_ff;
      end_in        = end_ff;
      stack_op      = '0;
      finish        = 1'b0;
      fail_now      = failed_ff;

      case (state_ff)
         spsc_pkg::S_IDLE: begin
            if (req_fire) begin
               if (failed_ff) begin
                  finish = 1'b1;
               end else if (hit) begin
                  stack_op.pop = 1'b1;
                  depth_in     = depth_ff - DEPTH_W'(1);
                  finish       = 1'b1;
               end else if (bad_val || over) begin
                  fail_now = 1'b1;
                  finish   = 1'b1;
               end else if (one_shot) begin
                  next_push_in = NP_W'(v_w + CMP_W'(1));
                  finish       = 1'b1;
               end else begin
                  target_in = req_chan.popped_value;
                  state_in  = spsc_pkg::S_PUSH;
               end
            end
         end
         spsc_pkg::S_PUSH: begin
            stack_op.push = 1'b1;
            depth_in      = depth_ff + DEPTH_W'(1);
            if ((np_w + CMP_W'(1)) == CMP_W'(target_ff)) begin
               next_push_in = NP_W'(CMP_W'(target_ff) + CMP_W'(1));
               state_in     = spsc_pkg::S_DONE;
            end else begin
               next_push_in = next_push_ff + NP_W'(1);
            end
         end
         spsc_pkg::S_DONE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = spsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spsc_pkg::S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in  = 1'b1;
         still_in      = !fail_now;
         end_in        = seq_done;
         failed_in     = fail_now;
         item_count_in = cnt_inc;
         if (seq_done) begin
            depth_in      = '0;
            next_push_in  = NP_W'(1);
            item_count_in = '0;
            failed_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff    <= spsc_pkg::SEQ_LEN_RESET;
         capacity_ff   <= spsc_pkg::CAPACITY_RESET;
         state_ff      <= spsc_pkg::S_IDLE;
         depth_ff      <= '0;
         next_push_ff  <= NP_W'(1);
         item_count_ff <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_len_ff    <= seq_len_in;
         capacity_ff   <= capacity_in;
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         next_push_ff  <= next_push_in;
         item_count_ff <= item_count_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      still_ff  <= still_in;
      end_ff    <= end_in;
   end

   spsc_stack_chain u_stack (
      .clock     (clock),
      .op        (stack_op),
      .push_data (VAL_W'(next_push_ff)),
      .top_data  (top_value)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.still_possible = still_ff;
   assign rsp_chan.sequence_end   = end_ff;

   `SPSC_ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_W'(spsc_pkg::MAX_DEPTH))
   `SPSC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, CMP_W'(item_count_ff) < CMP_W'(spsc_pkg::MAX_LEN))
   `SPSC_ASSERT_NOW(a_push_target, clock, reset, state_ff == spsc_pkg::S_PUSH, np_w < CMP_W'(target_ff))
   `SPSC_ASSERT_NXT(a_push_grows, clock, reset, state_ff == spsc_pkg::S_PUSH, depth_ff == $past(depth_ff) + DEPTH_W'(1))

endmodule
